// ===== sv/shc_pkg.sv =====
package shc_pkg;

	// Default build of the block.
	localparam int DEF_NUM_STRIPS = 8;
	localparam int DEF_AMP_BITS   = 16;

	// Fixed field widths.
	localparam int THR_W      = 15;
	localparam int FSP_W      = 16;
	localparam int PITCH_W    = 12;
	localparam int POS_W      = 16;
	localparam int LEAD_W     = 15;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_AMP_THRESHOLD   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_STRIP_POS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_PITCH     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_VETO_ON    = 8'd3;

	// Register values after reset.
	localparam logic [THR_W-1:0]   RST_AMP_THRESHOLD   = 15'd128;
	localparam logic [FSP_W-1:0]   RST_FIRST_STRIP_POS = 16'd3712;
	localparam logic [PITCH_W-1:0] RST_STRIP_PITCH     = 12'd128;
	localparam logic               RST_EDGE_VETO_ON    = 1'b0;

	localparam logic [POS_W-1:0]   POS_MAX   = 16'hFFFF;
	localparam logic [LEAD_W-1:0]  LEAD_MAX  = 15'h7FFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

endpackage

// ===== sv/shc_in_if.sv =====
interface shc_in_if #(
	parameter int NUM_STRIPS = 8,
	parameter int AMP_BITS   = 16
);
	logic                           valid;
	logic                           ready;
	logic [NUM_STRIPS*AMP_BITS-1:0] amp_s;
	logic                           is_dut_group;

	modport source (output valid, amp_s, is_dut_group, input ready);
	modport sink (input valid, amp_s, is_dut_group, output ready);
endinterface

// ===== sv/shc_out_if.sv =====
interface shc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  strip_count;
	logic        hit_valid;
	logic        edge_vetoed;
	logic [14:0] lead_amp;
	logic [15:0] pos_top2_lin;
	logic [15:0] pos_top2_sq;
	logic [15:0] pos_top3_lin;
	logic [15:0] pos_top3_sq;
	logic [15:0] pos_all_lin;
	logic [15:0] pos_all_sq;

	modport source (output valid, strip_count, hit_valid, edge_vetoed, lead_amp,
		pos_top2_lin, pos_top2_sq, pos_top3_lin, pos_top3_sq, pos_all_lin,
		pos_all_sq, input ready);
	modport sink (input valid, strip_count, hit_valid, edge_vetoed, lead_amp,
		pos_top2_lin, pos_top2_sq, pos_top3_lin, pos_top3_sq, pos_all_lin,
		pos_all_sq, output ready);
endinterface

// ===== sv/shc_cfg_if.sv =====
interface shc_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/shc_lane.sv =====
module shc_lane #(
	parameter int NUM_STRIPS = 8,
	parameter int AMP_BITS   = 16,
	parameter int LANE       = 0
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [NUM_STRIPS-1:0]                  hit,
	input  logic [NUM_STRIPS*(AMP_BITS-1)-1:0]     amp_flat,
	output logic [$clog2(NUM_STRIPS)-1:0]          rank_s2,
	output logic [2*(AMP_BITS-1)-1:0]              wsq_s2
);
	localparam int AW = AMP_BITS - 1;
	localparam int RW = $clog2(NUM_STRIPS);
	localparam int WW = 2 * AW;

	logic [AW-1:0] mine;
	logic [AW-1:0] other;
	logic [RW-1:0] rank_d;
	logic [WW-1:0] sq_d;

	assign mine = amp_flat[LANE*AW +: AW];

	// Count the qualifying strips that rank ahead of this one.
	always_comb begin
		rank_d = '0;
		other  = '0;
		for (int j = 0; j < NUM_STRIPS; j++) begin
			other = amp_flat[j*AW +: AW];
			if (j != LANE && hit[j] && (other > mine || (other == mine && j < LANE)))
				rank_d = rank_d + RW'(1);
		end
	end

	assign sq_d = WW'(mine) * WW'(mine);

	// Rank and squared weight of this strip.
	always_ff @(posedge clk) begin
		if (en) begin
			rank_s2 <= rank_d;
			wsq_s2  <= sq_d;
		end
	end
endmodule

// ===== sv/shc_cog.sv =====
module shc_cog #(
	parameter int NUM_STRIPS = 8,
	parameter int AMP_BITS   = 16,
	parameter int LIMIT      = 2
) (
	input  logic                                          clk,
	input  logic                                          en,
	input  logic [NUM_STRIPS-1:0]                         hit,
	input  logic [NUM_STRIPS*$clog2(NUM_STRIPS)-1:0]      rank_flat,
	input  logic [NUM_STRIPS*2*(AMP_BITS-1)-1:0]          w_flat,
	input  logic [shc_pkg::PITCH_W-1:0]                   pitch,
	output logic [shc_pkg::PITCH_W+$clog2(NUM_STRIPS)-1:0] quo,
	output logic                                          nz
);
	import shc_pkg::*;

	localparam int AW = AMP_BITS - 1;
	localparam int IW = $clog2(NUM_STRIPS);
	localparam int RW = IW;
	localparam int WW = 2 * AW;
	localparam int SW = WW + IW;
	localparam int TW = WW + 2 * IW;
	localparam int DW = TW + PITCH_W;
	localparam int QW = PITCH_W + IW;
	localparam int XW = DW + QW;

	logic [SW-1:0] s_d;
	logic [TW-1:0] t_d;
	logic [SW-1:0] s_s3;
	logic [TW-1:0] t_s3;

	logic [DW-1:0] rem_s [0:QW];
	logic [SW-1:0] dvs_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];

	// Weight sum and index-weighted sum over the selected strips.
	always_comb begin
		s_d = '0;
		t_d = '0;
		for (int i = 0; i < NUM_STRIPS; i++) begin
			if (hit[i] && int'(rank_flat[i*RW +: RW]) < LIMIT) begin
				s_d = s_d + SW'(w_flat[i*WW +: WW]);
				t_d = t_d + TW'(w_flat[i*WW +: WW]) * TW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s3 <= s_d;
			t_s3 <= t_d;
		end
	end

	// Scale by the pitch so that one division gives the offset directly.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(pitch) * DW'(t_s3);
			dvs_s[0] <= s_s3;
			quo_s[0] <= '0;
		end
	end

	// Restoring division, one quotient bit per stage, high bit first.
	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [XW-1:0] sh;
		logic [XW-1:0] rx;

		assign sh = XW'(dvs_s[k]) << B;
		assign rx = XW'(rem_s[k]);

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[k+1] <= dvs_s[k];
				if (rx >= sh) begin
					rem_s[k+1] <= DW'(rx - sh);
					quo_s[k+1] <= quo_s[k] | (QW'(1) << B);
				end else begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= quo_s[k];
				end
			end
		end
	end

	assign quo = quo_s[QW];
	assign nz  = (dvs_s[QW] != '0);
endmodule

// ===== sv/strip_hit_centroid.sv =====
// Strip hit centroid.
// One beat on evt carries the peak amplitudes of all strips and the group flag.
// One beat on res follows with the strip count, leading amplitude, veto flags
// and six center-of-gravity positions. Registers are written on cfg, which
// is always ready; write them only while no event is in flight.
// Throughput is one event per cycle while res is not stalled. From the evt beat
// to res valid, the threshold stage loads at the evt beat itself, the strip lanes
// take one more stage, the center-of-gravity units two more, then a restoring
// divider spends one stage per quotient bit, and an output register ends it.
// NUM_STRIPS lanes (eight by default) rank the strips in parallel; six centroid units run side by side.
// The whole pipeline advances together: while res is stalled with a result
// waiting, evt is not ready and every stage holds its contents.
// Reset clears all valid bits and loads the register defaults
// (threshold 128, first position 3712, pitch 128, veto off).
module strip_hit_centroid #(
	parameter int NUM_STRIPS = shc_pkg::DEF_NUM_STRIPS,
	parameter int AMP_BITS   = shc_pkg::DEF_AMP_BITS
) (
	input logic       clk,
	input logic       arst_n,
	shc_in_if.sink    evt,
	shc_out_if.source res,
	shc_cfg_if.sink   cfg
);
	import shc_pkg::*;

	localparam int AW  = AMP_BITS - 1;
	localparam int IW  = $clog2(NUM_STRIPS);
	localparam int RW  = IW;
	localparam int WW  = 2 * AW;
	localparam int QW  = PITCH_W + IW;
	localparam int CL  = 2 + QW;
	localparam int NST = 3 + CL;
	localparam int CW  = $clog2(NUM_STRIPS + 1);

	logic [THR_W-1:0]   amp_threshold_q;
	logic [FSP_W-1:0]   first_strip_pos_q;
	logic [PITCH_W-1:0] strip_pitch_q;
	logic               edge_veto_on_q;

	logic               adv;
	logic [NST-1:0]     vld_q;

	logic [NUM_STRIPS-1:0]      hit_d;
	logic [NUM_STRIPS*AW-1:0]   amp_d;
	logic [NUM_STRIPS-1:0]      hit_s1;
	logic [NUM_STRIPS*AW-1:0]   amp_s1;
	logic                       dut_s1;
	logic [NUM_STRIPS-1:0]      hit_s2;
	logic [NUM_STRIPS*AW-1:0]   amp_s2;
	logic                       dut_s2;
	logic [NUM_STRIPS*RW-1:0]   rank_s2;
	logic [NUM_STRIPS*WW-1:0]   wsq_s2;
	logic [NUM_STRIPS*WW-1:0]   wlin;

	logic [CW-1:0]     count_d;
	logic [IW-1:0]     lead_d;
	logic [AW-1:0]     lamp_d;
	logic              veto_d;
	logic [COUNT_W-1:0] cnt_o;
	logic [LEAD_W-1:0] lead_o;

	logic [COUNT_W-1:0] cnt_s   [0:CL-1];
	logic [LEAD_W-1:0]  lead_s  [0:CL-1];
	logic               veto_s  [0:CL-1];
	logic               ok_s    [0:CL-1];

	logic [QW-1:0] quo [0:5];
	logic          nz  [0:5];
	logic [POS_W-1:0] pos [0:5];

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_threshold_q   <= RST_AMP_THRESHOLD;
			first_strip_pos_q <= RST_FIRST_STRIP_POS;
			strip_pitch_q     <= RST_STRIP_PITCH;
			edge_veto_on_q    <= RST_EDGE_VETO_ON;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_AMP_THRESHOLD:   amp_threshold_q   <= cfg.data[THR_W-1:0];
				REG_FIRST_STRIP_POS: first_strip_pos_q <= cfg.data[FSP_W-1:0];
				REG_STRIP_PITCH:     strip_pitch_q     <= cfg.data[PITCH_W-1:0];
				REG_EDGE_VETO_ON:    edge_veto_on_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Pipeline advance and valid tracking.
	assign adv       = !vld_q[NST-1] || res.ready;
	assign evt.ready = adv;
	assign res.valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], evt.valid};
		end
	end

	// Threshold test per strip; strips that fail carry zero amplitude.
	always_comb begin
		hit_d = '0;
		amp_d = '0;
		for (int i = 0; i < NUM_STRIPS; i++) begin
			if (!evt.amp_s[i*AMP_BITS + AW] &&
			    32'(evt.amp_s[i*AMP_BITS +: AW]) > 32'(amp_threshold_q)) begin
				hit_d[i]          = 1'b1;
				amp_d[i*AW +: AW] = evt.amp_s[i*AMP_BITS +: AW];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s1 <= hit_d;
			amp_s1 <= amp_d;
			dut_s1 <= evt.is_dut_group;
			hit_s2 <= hit_s1;
			amp_s2 <= amp_s1;
			dut_s2 <= dut_s1;
		end
	end

	// Strip lanes.
	for (genvar g = 0; g < NUM_STRIPS; g++) begin : g_lane
		shc_lane #(
			.NUM_STRIPS(NUM_STRIPS),
			.AMP_BITS  (AMP_BITS),
			.LANE      (g)
		) u_lane (
			.clk     (clk),
			.en      (adv),
			.hit     (hit_s1),
			.amp_flat(amp_s1),
			.rank_s2 (rank_s2[g*RW +: RW]),
			.wsq_s2  (wsq_s2[g*WW +: WW])
		);
		assign wlin[g*WW +: WW] = WW'(amp_s2[g*AW +: AW]);
	end

	// Merge lane results: count, leading strip and edge veto.
	always_comb begin
		count_d = '0;
		lead_d  = '0;
		lamp_d  = '0;
		for (int i = 0; i < NUM_STRIPS; i++) begin
			if (hit_s2[i]) begin
				count_d = count_d + CW'(1);
				if (rank_s2[i*RW +: RW] == '0) begin
					lead_d = IW'(i);
					lamp_d = amp_s2[i*AW +: AW];
				end
			end
		end
		veto_d = (count_d != '0) && edge_veto_on_q &&
			(lead_d == '0 ||
			 int'(lead_d) == (dut_s2 ? NUM_STRIPS - 2 : NUM_STRIPS - 1));
		cnt_o  = (32'(count_d) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count_d);
		lead_o = (32'(lamp_d) > 32'(LEAD_MAX)) ? LEAD_MAX : LEAD_W'(lamp_d);
	end

	// Side data delayed to line up with the divider outputs.
	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_s[0]  <= cnt_o;
			lead_s[0] <= lead_o;
			veto_s[0] <= veto_d;
			ok_s[0]   <= (count_d != '0) && !veto_d;
			for (int k = 1; k < CL; k++) begin
				cnt_s[k]  <= cnt_s[k-1];
				lead_s[k] <= lead_s[k-1];
				veto_s[k] <= veto_s[k-1];
				ok_s[k]   <= ok_s[k-1];
			end
		end
	end

	// Centroid units: top two, top three, all; linear then squared.
	for (genvar u = 0; u < 6; u++) begin : g_cog
		localparam int LIM = (u < 2) ? 2 : ((u < 4) ? 3 : NUM_STRIPS);
		shc_cog #(
			.NUM_STRIPS(NUM_STRIPS),
			.AMP_BITS  (AMP_BITS),
			.LIMIT     (LIM)
		) u_cog (
			.clk      (clk),
			.en       (adv),
			.hit      (hit_s2),
			.rank_flat(rank_s2),
			.w_flat   ((u % 2 == 0) ? wlin : wsq_s2),
			.pitch    (strip_pitch_q),
			.quo      (quo[u]),
			.nz       (nz[u])
		);

		logic [31:0] sum;
		assign sum    = 32'(first_strip_pos_q) + 32'(quo[u]);
		assign pos[u] = (!ok_s[CL-1] || !nz[u]) ? '0 :
			((sum > 32'(POS_MAX)) ? POS_MAX : POS_W'(sum));
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			res.strip_count  <= cnt_s[CL-1];
			res.hit_valid    <= ok_s[CL-1];
			res.edge_vetoed  <= veto_s[CL-1];
			res.lead_amp     <= lead_s[CL-1];
			res.pos_top2_lin <= pos[0];
			res.pos_top2_sq  <= pos[1];
			res.pos_top3_lin <= pos[2];
			res.pos_top3_sq  <= pos[3];
			res.pos_all_lin  <= pos[4];
			res.pos_all_sq   <= pos[5];
		end
	end

	// A valid hit is never also vetoed.
	a_hit_not_vetoed: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.hit_valid && res.edge_vetoed))
		else $error("hit_valid and edge_vetoed both set");

	// An empty event carries no leading amplitude and no hit.
	a_empty_event: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.strip_count == '0 |-> res.lead_amp == '0 && !res.hit_valid)
		else $error("empty event with lead amplitude or hit");

	// Vetoed results carry zero positions (checked on pos_all_lin and pos_top2_sq).
	a_veto_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.edge_vetoed |-> res.pos_all_lin == '0 && res.pos_top2_sq == '0)
		else $error("vetoed result with nonzero position");

	// A stalled result is held by the pipeline.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.pos_all_sq))
		else $error("result changed while stalled");
endmodule
